@@ rtl/digit_glyph_rect_generator_assert.svh @@
// Assertion macros used by the checker file.
`ifndef DIGIT_GLYPH_RECT_GENERATOR_ASSERT_SVH
`define DIGIT_GLYPH_RECT_GENERATOR_ASSERT_SVH

// Property that must hold at every rising clock edge outside reset.
`define DGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define DGR_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/dgr_pkg.sv @@
package dgr_pkg;

  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned SCREEN_MAX = 4096;

  localparam int unsigned DIM_W   = 13;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned F_W     = DIM_W + SCALE_W;
  localparam int unsigned PX_W    = 26;
  localparam int unsigned PY_W    = 25;
  localparam int unsigned EDGE_W  = 28;
  localparam int unsigned PROD_W  = EDGE_W + F_W + 1;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned FRAC_W  = 25;
  localparam int unsigned DCNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned QDEPTH  = 2;

  // Reciprocal of ten: quotient is (n * RECIP10) >> 35 for any 32-bit n.
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_UNIT_SCALE    = 2'd2
  } dgr_reg_e;

  typedef struct packed {
    logic [30:0] value;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0] glyph_size;
    logic [31:0] paint;
  } dgr_in_t;

  typedef struct packed {
    logic [12:0] left;
    logic [12:0] top;
    logic [12:0] right;
    logic [12:0] bottom;
    logic [31:0] fill_color;
    logic        last;
  } dgr_out_t;

  // One digit handed from the front to the back.
  typedef struct packed {
    logic [3:0]             digit;
    logic signed [PX_W-1:0] px;
    logic signed [PY_W-1:0] py;
    logic [15:0]            g;
    logic [31:0]            color;
    logic                   fin;
  } dgr_dig_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [F_W-1:0]   f;
  } dgr_cfg_t;

  typedef struct packed {
    logic signed [2:0] dx;
    logic signed [2:0] dy;
    logic [2:0]        hx;
    logic [2:0]        hy;
  } dgr_seg_t;

  localparam logic [2:0] SEG_COUNT [10] = '{
    3'd4, 3'd1, 3'd5, 3'd5, 3'd3, 3'd5, 3'd5, 3'd2, 3'd5, 3'd5
  };

  localparam dgr_seg_t SEG_TABLE [10][5] = '{
    '{'{-3'sd1, 3'sd0, 3'd1, 3'd5}, '{3'sd1, 3'sd0, 3'd1, 3'd5},
      '{3'sd0, 3'sd2, 3'd1, 3'd1}, '{3'sd0, -3'sd2, 3'd1, 3'd1},
      '{3'sd0, 3'sd0, 3'd0, 3'd0}},
    '{'{3'sd0, 3'sd0, 3'd1, 3'd5}, '{3'sd0, 3'sd0, 3'd0, 3'd0},
      '{3'sd0, 3'sd0, 3'd0, 3'd0}, '{3'sd0, 3'sd0, 3'd0, 3'd0},
      '{3'sd0, 3'sd0, 3'd0, 3'd0}},
    '{'{3'sd1, 3'sd1, 3'd1, 3'd3}, '{-3'sd1, -3'sd1, 3'd1, 3'd3},
      '{3'sd0, 3'sd0, 3'd3, 3'd1}, '{3'sd0, -3'sd2, 3'd3, 3'd1},
      '{3'sd0, 3'sd2, 3'd3, 3'd1}},
    '{'{3'sd1, 3'sd1, 3'd1, 3'd3}, '{3'sd1, -3'sd1, 3'd1, 3'd3},
      '{3'sd0, 3'sd0, 3'd3, 3'd1}, '{3'sd0, -3'sd2, 3'd3, 3'd1},
      '{3'sd0, 3'sd2, 3'd3, 3'd1}},
    '{'{-3'sd1, 3'sd1, 3'd1, 3'd3}, '{3'sd0, 3'sd0, 3'd3, 3'd1},
      '{3'sd1, 3'sd0, 3'd1, 3'd5}, '{3'sd0, 3'sd0, 3'd0, 3'd0},
      '{3'sd0, 3'sd0, 3'd0, 3'd0}},
    '{'{-3'sd1, 3'sd1, 3'd1, 3'd3}, '{3'sd1, -3'sd1, 3'd1, 3'd3},
      '{3'sd0, 3'sd0, 3'd3, 3'd1}, '{3'sd0, -3'sd2, 3'd3, 3'd1},
      '{3'sd0, 3'sd2, 3'd3, 3'd1}},
    '{'{3'sd1, -3'sd1, 3'd1, 3'd3}, '{-3'sd1, 3'sd0, 3'd1, 3'd5},
      '{3'sd0, 3'sd0, 3'd3, 3'd1}, '{3'sd0, -3'sd2, 3'd3, 3'd1},
      '{3'sd0, 3'sd2, 3'd3, 3'd1}},
    '{'{3'sd1, 3'sd0, 3'd1, 3'd5}, '{3'sd0, 3'sd2, 3'd3, 3'd1},
      '{3'sd0, 3'sd0, 3'd0, 3'd0}, '{3'sd0, 3'sd0, 3'd0, 3'd0},
      '{3'sd0, 3'sd0, 3'd0, 3'd0}},
    '{'{3'sd1, 3'sd0, 3'd1, 3'd5}, '{-3'sd1, 3'sd0, 3'd1, 3'd5},
      '{3'sd0, 3'sd0, 3'd3, 3'd1}, '{3'sd0, -3'sd2, 3'd3, 3'd1},
      '{3'sd0, 3'sd2, 3'd3, 3'd1}},
    '{'{3'sd1, 3'sd0, 3'd1, 3'd5}, '{-3'sd1, 3'sd1, 3'd1, 3'd3},
      '{3'sd0, 3'sd0, 3'd3, 3'd1}, '{3'sd0, -3'sd2, 3'd3, 3'd1},
      '{3'sd0, 3'sd2, 3'd3, 3'd1}}
  };

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [15:0] v);
    logic [DIM_W-1:0] t;
    t = v[DIM_W-1:0];
    if (t == '0) begin
      return DIM_W'(1);
    end else if (t > DIM_W'(SCREEN_MAX)) begin
      return DIM_W'(SCREEN_MAX);
    end
    return t;
  endfunction

endpackage

@@ rtl/digit_glyph_rect_generator.sv @@
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_we_i                cfg_idx_i, cfg_data_i
// in        in         in_valid_i / in_stall_o in_data_i  (dgr_in_t)
// out       out        out_valid_o/out_stall_i out_data_o (dgr_out_t)
//
// The front splits off one decimal digit at a time through a
// reciprocal multiply and queues it; the back builds each rectangle
// in steps (edges, multiply and clamp for x, then for y) and takes a
// new digit from the queue only when it is idle.
// Output stalls hold the back, which backs up through the digit queue.
// Reset is asynchronous and loads 1280, 720 and 655 into the registers.
module digit_glyph_rect_generator import dgr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  dgr_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output dgr_out_t    out_data_o
);

  logic [DIM_W-1:0]   width_q, height_q;
  logic [SCALE_W-1:0] scale_q;
  logic [F_W-1:0]     f_q;
  dgr_cfg_t           cfg;

  logic     push, full, pop, qvalid;
  dgr_dig_t push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1280);
      height_q <= DIM_W'(720);
      scale_q  <= SCALE_W'(655);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCREEN_WIDTH:  width_q  <= clamp_dim(cfg_data_i);
        REG_SCREEN_HEIGHT: height_q <= clamp_dim(cfg_data_i);
        REG_UNIT_SCALE:    scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pixels per game unit, refreshed every cycle from the registers.
  always_ff @(posedge clk_i) begin
    f_q <= F_W'(height_q) * F_W'(scale_q);
  end

  assign cfg = '{width: width_q, height: height_q, f: f_q};

  dgr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .push_o(push), .full_i(full), .push_data_o(push_data)
  );

  dgr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .valid_o(qvalid), .pop_data_o(pop_data)
  );

  dgr_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .valid_i(qvalid), .data_i(pop_data),
    .pop_o(pop), .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

@@ rtl/dgr_front.sv @@
module dgr_front import dgr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dgr_in_t  in_data_i,
  output logic     push_o,
  input  logic     full_i,
  output dgr_dig_t push_data_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e           state_q, state_d;
  logic [30:0]            num_q;
  logic [62:0]            prod_q;
  logic signed [PX_W-1:0] px_q;
  logic signed [PY_W-1:0] py_q;
  logic [15:0]            g_q;
  logic [31:0]            color_q;
  logic [DCNT_W-1:0]      cnt_q;

  logic [27:0] quo;
  logic [30:0] rem_full;
  logic [3:0]  rem;
  logic        fin;
  logic [18:0] step;

  assign quo      = prod_q[62:RECIP_SHIFT];
  assign rem_full = num_q - ({3'b0, quo} << 3) - ({3'b0, quo} << 1);
  assign rem      = rem_full[3:0];
  assign fin      = (quo == '0) || (cnt_q == DCNT_W'(MAX_DIGITS - 1));
  // A one is narrower than the other digits.
  assign step     = (rem == 4'd1) ? (19'({g_q, 1'b0}) + 19'({g_q, 2'b0}))
                                  : 19'({g_q, 3'b0});

  assign in_stall_o = (state_q != F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign push_data_o = '{digit: rem, px: px_q, py: py_q, g: g_q,
                         color: color_q, fin: fin};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) state_d = F_MUL;
      end
      F_MUL: state_d = F_PUSH;
      F_PUSH: begin
        if (!full_i) state_d = fin ? F_IDLE : F_MUL;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_IDLE && in_valid_i) begin
        cnt_q <= '0;
      end else if (push_o) begin
        cnt_q <= cnt_q + DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      num_q   <= in_data_i.value;
      px_q    <= PX_W'($signed({in_data_i.pos_x, 1'b0}));
      py_q    <= $signed({in_data_i.pos_y, 1'b0});
      g_q     <= in_data_i.glyph_size;
      color_q <= in_data_i.paint;
    end
    if (state_q == F_MUL) begin
      prod_q <= 63'(num_q) * 63'(RECIP10);
    end
    if (push_o) begin
      num_q <= 31'(quo);
      px_q  <= px_q - $signed({{(PX_W-19){1'b0}}, step});
    end
  end

endmodule

@@ rtl/dgr_queue.sv @@
module dgr_queue import dgr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  dgr_dig_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output dgr_dig_t pop_data_o
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  dgr_dig_t          mem_q [QDEPTH];
  logic [PTR_W-1:0]  rd_q, wr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o     = (cnt_q == CNT_W'(QDEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      if (pop_i)  rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

@@ rtl/dgr_back.sv @@
module dgr_back import dgr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dgr_cfg_t cfg_i,
  input  logic     valid_i,
  input  dgr_dig_t data_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dgr_out_t out_data_o
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_EDGE = 4'b0010,
    B_MUL  = 4'b0100,
    B_PIX  = 4'b1000
  } back_state_e;

  back_state_e              state_q, state_d;
  dgr_dig_t                 ent_q;
  logic [2:0]               k_q;
  logic                     yax_q;
  logic signed [EDGE_W-1:0] lo_q, hi_q;
  logic signed [PROD_W-1:0] plo_q, phi_q;
  logic [DIM_W-1:0]         xl_q, xr_q;
  dgr_out_t                 out_q;
  logic                     out_valid_q;

  dgr_seg_t                 seg;
  logic signed [EDGE_W-1:0] ctr, half;
  logic signed [SUM_W-1:0]  off;
  logic [DIM_W-1:0]         bound, pix_lo, pix_hi;
  logic                     out_free, last_seg, load;

  function automatic logic [DIM_W-1:0] to_pix(input logic signed [SUM_W-1:0] v,
                                               input logic [DIM_W-1:0] b);
    logic [SUM_W-FRAC_W-1:0] p;
    p = v[SUM_W-1:FRAC_W];
    // Negative values truncate to zero or below and clamp to zero.
    if (v < 0) return '0;
    if (p > (SUM_W-FRAC_W)'(b)) return b;
    return p[DIM_W-1:0];
  endfunction

  assign seg = SEG_TABLE[ent_q.digit][k_q];

  always_comb begin
    if (yax_q) begin
      ctr  = EDGE_W'(ent_q.py) + EDGE_W'(seg.dy) * $signed({1'b0, ent_q.g, 1'b0});
      half = $signed(EDGE_W'(seg.hy) * EDGE_W'(ent_q.g));
    end else begin
      ctr  = EDGE_W'(ent_q.px) + EDGE_W'(seg.dx) * $signed({1'b0, ent_q.g, 1'b0});
      half = $signed(EDGE_W'(seg.hx) * EDGE_W'(ent_q.g));
    end
  end

  assign bound  = yax_q ? cfg_i.height : cfg_i.width;
  assign off    = $signed({{(SUM_W-DIM_W-FRAC_W+1){1'b0}}, bound, {(FRAC_W-1){1'b0}}});
  assign pix_lo = to_pix(SUM_W'(plo_q) + off, bound);
  assign pix_hi = to_pix(SUM_W'(phi_q) + off, bound);

  assign out_free = !out_valid_q || !out_stall_i;
  assign last_seg = (k_q == SEG_COUNT[ent_q.digit] - 3'd1);
  assign load     = (state_q == B_PIX) && yax_q && out_free;
  assign pop_o    = (state_q == B_IDLE) && valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (valid_i) state_d = B_EDGE;
      B_EDGE: state_d = B_MUL;
      B_MUL:  state_d = B_PIX;
      B_PIX: begin
        if (!yax_q) begin
          state_d = B_EDGE;
        end else if (out_free) begin
          state_d = last_seg ? B_IDLE : B_EDGE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      yax_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        k_q   <= '0;
        yax_q <= 1'b0;
      end else if (state_q == B_PIX && !yax_q) begin
        yax_q <= 1'b1;
      end else if (load) begin
        yax_q <= 1'b0;
        k_q   <= k_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= data_i;
    if (state_q == B_EDGE) begin
      lo_q <= ctr - half;
      hi_q <= ctr + half;
    end
    if (state_q == B_MUL) begin
      plo_q <= PROD_W'(lo_q) * PROD_W'($signed({1'b0, cfg_i.f}));
      phi_q <= PROD_W'(hi_q) * PROD_W'($signed({1'b0, cfg_i.f}));
    end
    if (state_q == B_PIX && !yax_q) begin
      xl_q <= pix_lo;
      xr_q <= pix_hi;
    end
    if (load) begin
      out_q <= '{left: xl_q, top: pix_lo, right: xr_q, bottom: pix_hi,
                 fill_color: ent_q.color, last: ent_q.fin && last_seg};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/dgr_checker.sv @@
`include "digit_glyph_rect_generator_assert.svh"

module dgr_checker import dgr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input dgr_out_t out_data_o
);

  `DGR_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `DGR_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_data_o), "stalled result changed")
  `DGR_ASSERT_NEVER(a_order, out_valid_o && ((out_data_o.left > out_data_o.right) || (out_data_o.top > out_data_o.bottom)), "rectangle edges out of order")
  `DGR_ASSERT_NEVER(a_bound, out_valid_o && ((out_data_o.right > 13'(SCREEN_MAX)) || (out_data_o.bottom > 13'(SCREEN_MAX))), "rectangle beyond screen limit")

endmodule

bind digit_glyph_rect_generator dgr_checker u_dgr_checker (.*);

@@ test/digit_glyph_rect_generator_test.sv @@
module digit_glyph_rect_generator_test;
  import dgr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  dgr_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  dgr_out_t out_data_o;

  digit_glyph_rect_generator dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor copy of the registers.
  logic [12:0] scr_w;
  logic [12:0] scr_h;
  logic [15:0] scale;

  dgr_out_t rect_q[$];
  int errors = 0;
  int cycles = 0;
  bit stall_rand = 1'b1;
  bit long_hold = 1'b0;

  typedef struct {
    dgr_in_t item;
    bit has_first;
    dgr_out_t first_rect;
  } stim_row_t;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic logic [12:0] edge_pixel(input longint q25, input logic [12:0] bound);
    longint p;
    if (q25 < 0) begin
      p = -((-q25) >>> 25);
    end else begin
      p = q25 >>> 25;
    end
    if (p < 0) p = 0;
    if (p > longint'(bound)) p = bound;
    return p[12:0];
  endfunction

  task automatic predict_rects(input dgr_in_t it);
    longint ux, uy, g, f, cx, cy, hx, hy;
    int unsigned num, d, cnt;
    dgr_out_t r;
    dgr_seg_t s;
    num = it.value;
    ux = longint'(it.pos_x) * 2;
    uy = longint'(it.pos_y) * 2;
    g = it.glyph_size;
    f = longint'(scr_h) * longint'(scale);
    cnt = 0;
    do begin
      d = num % 10;
      num = num / 10;
      for (int k = 0; k < SEG_COUNT[d]; k++) begin
        s = SEG_TABLE[d][k];
        cx = (ux + 2 * longint'(s.dx) * g) * f + (longint'(scr_w) << 24);
        cy = (uy + 2 * longint'(s.dy) * g) * f + (longint'(scr_h) << 24);
        hx = longint'(s.hx) * g * f;
        hy = longint'(s.hy) * g * f;
        r.left = edge_pixel(cx - hx, scr_w);
        r.top = edge_pixel(cy - hy, scr_h);
        r.right = edge_pixel(cx + hx, scr_w);
        r.bottom = edge_pixel(cy + hy, scr_h);
        r.fill_color = it.paint;
        r.last = 1'b0;
        rect_q.push_back(r);
      end
      ux -= (d == 1) ? 6 * g : 8 * g;
      cnt++;
    end while (num != 0 && cnt < MAX_DIGITS);
    rect_q[$].last = 1'b1;
  endtask

  function automatic logic [12:0] dim_of(input logic [15:0] v);
    logic [12:0] t;
    t = v[12:0];
    if (t == 0) return 13'd1;
    if (t > 13'd4096) return 13'd4096;
    return t;
  endfunction

  task automatic write_reg(input dgr_reg_e idx, input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH: scr_w = dim_of(v);
      REG_SCREEN_HEIGHT: scr_h = dim_of(v);
      REG_UNIT_SCALE: scale = v;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (rect_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Sends one item at a falling edge and holds it until the transfer.
  task automatic send_item(input dgr_in_t it, input bit gaps);
    @(negedge clk_i);
    if (gaps && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_rects(it);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic dgr_in_t rand_item();
    dgr_in_t it;
    it.value = {$urandom} >> ($urandom_range(0, 31) + 1);
    if ($urandom_range(0, 7) == 0) it.value = {$urandom} >> 1;
    it.pos_x = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($signed($urandom_range(0, 8191)) - 4096);
    it.pos_y = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($signed($urandom_range(0, 8191)) - 4096);
    it.glyph_size = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024));
    it.paint = $urandom;
    return it;
  endfunction

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        out_stall_i <= 1'b0;
        long_hold = 1'b0;
      end else if (stall_rand && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    dgr_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rect_q.size() == 0) begin
        report("unexpected rectangle", out_data_o.fill_color, 0);
      end else begin
        want = rect_q.pop_front();
        if (out_data_o.left !== want.left) report("left", out_data_o.left, want.left);
        if (out_data_o.top !== want.top) report("top", out_data_o.top, want.top);
        if (out_data_o.right !== want.right) report("right", out_data_o.right, want.right);
        if (out_data_o.bottom !== want.bottom)
          report("bottom", out_data_o.bottom, want.bottom);
        if (out_data_o.fill_color !== want.fill_color)
          report("fill_color", out_data_o.fill_color, want.fill_color);
        if (out_data_o.last !== want.last) report("last", out_data_o.last, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[digit_glyph_rect_generator] ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    dgr_out_t probe;
    int head;
    scr_w = 13'd1280;
    scr_h = 13'd720;
    scale = 16'd655;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Zero at the origin with zero size: a point at the screen centre.
    row = '{'{31'd0, 24'sd0, 24'sd0, 16'd0, 32'hDEAD_BEEF}, 1'b1,
            '{13'd640, 13'd360, 13'd640, 13'd360, 32'hDEAD_BEEF, 1'b0}};
    rows.push_back(row);
    for (int d = 1; d <= 9; d++) begin
      row = '{'{31'(d), 24'sd256, -24'sd512, 16'd256, 32'(d * 32'h1111_1111)}, 1'b0, '0};
      rows.push_back(row);
    end
    row = '{'{31'h7FFF_FFFF, 24'sh7F_FFFF, 24'sh80_0000, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, '0};
    rows.push_back(row);
    row = '{'{31'd1234567890, 24'sh80_0000, 24'sh7F_FFFF, 16'd0, 32'h0}, 1'b0, '0};
    rows.push_back(row);
    row = '{'{31'd1000000000, 24'sd1000, 24'sd0, 16'd128, 32'h5555_AAAA}, 1'b0, '0};
    rows.push_back(row);
    row = '{'{31'd10, -24'sd3000, 24'sd100, 16'd64, 32'hAAAA_5555}, 1'b0, '0};
    rows.push_back(row);
    foreach (rows[i]) begin
      head = rect_q.size();
      send_item(rows[i].item, 1'b1);
      if (rows[i].has_first) begin
        probe = rect_q[head];
        if (probe !== rows[i].first_rect) report("table row", probe.left, rows[i].first_rect.left);
      end
    end
    wait_idle();

    // Extremes of the registers, including the out-of-range codes.
    write_reg(REG_SCREEN_WIDTH, 16'd0);
    write_reg(REG_SCREEN_HEIGHT, 16'hFFFF);
    write_reg(REG_UNIT_SCALE, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_item(rand_item(), 1'b1);
    wait_idle();
    write_reg(REG_SCREEN_WIDTH, 16'd4097);
    write_reg(REG_SCREEN_HEIGHT, 16'd1);
    write_reg(REG_UNIT_SCALE, 16'd0);
    for (int i = 0; i < 6; i++) send_item(rand_item(), 1'b1);
    wait_idle();
    write_reg(REG_SCREEN_WIDTH, 16'd4096);
    write_reg(REG_SCREEN_HEIGHT, 16'd4096);
    write_reg(REG_UNIT_SCALE, 16'd6553);
    // Long receiver hold-off while the sender keeps offering.
    long_hold = 1'b1;
    for (int i = 0; i < 20; i++) send_item(rand_item(), 1'b0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_SCREEN_WIDTH, 16'($urandom_range(1, 4096)));
      write_reg(REG_SCREEN_HEIGHT, 16'($urandom_range(1, 4096)));
      write_reg(REG_UNIT_SCALE, 16'($urandom_range(0, 2000)));
      if (ph == 3) stall_rand = 1'b0;
      for (int i = 0; i < 45; i++) send_item(rand_item(), ph != 3);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && rect_q.size() == 0) begin
      $display("[digit_glyph_rect_generator] OK");
    end else begin
      $display("[digit_glyph_rect_generator] ERROR");
    end
    $finish;
  end
endmodule

@@ digit_glyph_rect_generator.f @@
+incdir+rtl
rtl/dgr_pkg.sv
rtl/dgr_front.sv
rtl/dgr_queue.sv
rtl/dgr_back.sv
rtl/digit_glyph_rect_generator.sv
rtl/dgr_checker.sv
test/digit_glyph_rect_generator_test.sv
